>>> rtl/polynomial_multiplier_top_assert.svh
// Assertion macros for the polynomial multiplier RTL.
`ifndef POLYNOMIAL_MULTIPLIER_TOP_ASSERT_SVH
`define POLYNOMIAL_MULTIPLIER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("polynomial multiplier check failed");
`define PM_NEVER(lbl, cond) \
  `PM_ASSERT(lbl, !(cond))
`else
`define PM_ASSERT(lbl, prop)
`define PM_NEVER(lbl, cond)
`endif
`endif

>>> rtl/pm_pkg.sv
`default_nettype none
package pm_pkg;

  localparam int MAX_TERMS = 32;
  localparam int ADDR_W    = $clog2(MAX_TERMS);
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int COEF_W    = 32;
  localparam int POWER_W   = 6;
  localparam int PROD_W    = 2 * COEF_W;
  // Room for MAX_TERMS full-scale products plus the rounding constant.
  localparam int ACC_W     = PROD_W + $clog2(MAX_TERMS) + 2;
  localparam int FRAC_W    = 16;

  typedef enum logic [1:0] {
    CMD_LOAD_FIRST  = 2'd0,
    CMD_LOAD_SECOND = 2'd1,
    CMD_COMPUTE     = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic issue;
    logic clear;
  } mac_ctl_t;

  typedef struct packed {
    logic              busy;
    logic              saturated;
    logic [COEF_W-1:0] value;
  } mac_stat_t;

endpackage
`default_nettype wire

>>> rtl/pm_ram.sv
`default_nettype none
module pm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/pm_mac.sv
`default_nettype none
module pm_mac (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire pm_pkg::mac_ctl_t           ctl,
  input  wire logic [pm_pkg::COEF_W-1:0]  a,
  input  wire logic [pm_pkg::COEF_W-1:0]  b,
  output pm_pkg::mac_stat_t               stat
);

  localparam int Q_W = pm_pkg::ACC_W - pm_pkg::FRAC_W;

  logic                               rd_valid;
  logic                               prod_valid;
  logic signed [pm_pkg::PROD_W-1:0]   product;
  logic signed [pm_pkg::ACC_W-1:0]    acc;
  logic signed [pm_pkg::ACC_W-1:0]    rounded;
  logic signed [Q_W-1:0]              q;
  logic                               fits;

  // Read data arrives in the cycle after issue; the product is registered
  // before it is added in.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      prod_valid <= 1'b0;
      acc        <= '0;
    end else begin
      rd_valid   <= ctl.issue;
      prod_valid <= rd_valid;
      if (ctl.clear) begin
        acc <= '0;
      end else if (prod_valid) begin
        acc <= acc + pm_pkg::ACC_W'(product);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      product <= $signed(a) * $signed(b);
    end
  end

  // Round to nearest with ties toward plus infinity, then clip to 32 bits.
  always_comb begin
    rounded = acc + pm_pkg::ACC_W'(1 << (pm_pkg::FRAC_W - 1));
    q       = rounded[pm_pkg::ACC_W-1:pm_pkg::FRAC_W];
    fits    = (q[Q_W-1:pm_pkg::COEF_W-1] == '0) || (q[Q_W-1:pm_pkg::COEF_W-1] == '1);
    stat.busy      = rd_valid | prod_valid;
    stat.saturated = !fits;
    if (fits) begin
      stat.value = q[pm_pkg::COEF_W-1:0];
    end else if (q[Q_W-1]) begin
      stat.value = {1'b1, {(pm_pkg::COEF_W-1){1'b0}}};
    end else begin
      stat.value = {1'b0, {(pm_pkg::COEF_W-1){1'b1}}};
    end
  end

endmodule
`default_nettype wire

>>> rtl/polynomial_multiplier_top.sv
// Polynomial multiplier, linear convolution of two coefficient vectors.
// Input channel s_axis: tuser carries the command (append to the first
// operand, append to the second operand, compute), tdata the signed Q16.16
// coefficient. Appends produce no item; an append to a full operand is
// dropped and reported on the next product.
// A compute emits n+m-1 items on m_axis, lowest power first, tlast on the
// highest power, then empties both operands. An empty operand gives one
// zero item with empty status.
// Output coefficient k is worked one contributing term pair (at most 32)
// at a time through memory read, multiply, accumulate and the output
// register; the single multiply-accumulate unit and one read port per
// operand memory set this pace. The input is not taken while a product
// is being worked.
// The output register holds an item until m_axis_tready; a stall pauses the
// sequencer, and appends are still taken while the last item waits.
// Reset (rst, synchronous) empties both operands and drops any item.
`default_nettype none
`include "polynomial_multiplier_top_assert.svh"
module polynomial_multiplier_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // [31:0] coefficient
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // [31:0] product_coefficient, [37:32] power
  output logic             m_axis_tlast,  // last_term
  output logic [2:0]       m_axis_tuser   // [0] saturated, [2:1] status
);

  localparam int AW = pm_pkg::ADDR_W;
  localparam int CW = pm_pkg::CNT_W;
  localparam int PW = pm_pkg::POWER_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t              state;
  logic [CW-1:0]       first_count;
  logic [CW-1:0]       second_count;
  logic                overflow_seen;
  logic                empty_run;
  logic [PW-1:0]       k;
  logic [AW-1:0]       i;

  logic                accept;
  logic                load_first;
  logic                load_second;
  logic                start;
  logic                emit;
  logic                last;
  logic [PW-1:0]       k_next;
  logic [PW-1:0]       i_hi;
  logic [PW-1:0]       i_lo_next;
  logic [PW-1:0]       b_index;
  logic [pm_pkg::COEF_W-1:0] first_rd;
  logic [pm_pkg::COEF_W-1:0] second_rd;
  pm_pkg::mac_ctl_t    mac_ctl;
  pm_pkg::mac_stat_t   mac_stat;
  pm_pkg::status_t     status;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign load_first    = accept && (s_axis_tuser == pm_pkg::CMD_LOAD_FIRST);
  assign load_second   = accept && (s_axis_tuser == pm_pkg::CMD_LOAD_SECOND);
  assign start         = accept && (s_axis_tuser == pm_pkg::CMD_COMPUTE);
  assign emit          = (state == ST_EMIT) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    last      = empty_run || ((7'(k) + 7'd2) == (7'(first_count) + 7'(second_count)));
    k_next    = k + PW'(1);
    // Terms of power k run from i = max(0, k-m+1) to min(k, n-1).
    i_hi      = (k < PW'(first_count - CW'(1))) ? k : PW'(first_count - CW'(1));
    i_lo_next = (k_next >= PW'(second_count)) ? (k_next - PW'(second_count) + PW'(1)) : '0;
    b_index   = k - PW'(i);
    mac_ctl.issue = (state == ST_ISSUE);
    mac_ctl.clear = emit;
    if (empty_run) begin
      status = pm_pkg::STATUS_EMPTY;
    end else if (overflow_seen) begin
      status = pm_pkg::STATUS_OVERFLOW;
    end else begin
      status = pm_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      first_count   <= '0;
      second_count  <= '0;
      overflow_seen <= 1'b0;
      empty_run     <= 1'b0;
      k             <= '0;
      i             <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (load_first) begin
            if (first_count < CW'(pm_pkg::MAX_TERMS)) begin
              first_count <= first_count + CW'(1);
            end else begin
              overflow_seen <= 1'b1;
            end
          end
          if (load_second) begin
            if (second_count < CW'(pm_pkg::MAX_TERMS)) begin
              second_count <= second_count + CW'(1);
            end else begin
              overflow_seen <= 1'b1;
            end
          end
          if (start) begin
            k <= '0;
            i <= '0;
            if (first_count == '0 || second_count == '0) begin
              empty_run <= 1'b1;
              state     <= ST_EMIT;
            end else begin
              empty_run <= 1'b0;
              state     <= ST_ISSUE;
            end
          end
        end
        ST_ISSUE: begin
          if (PW'(i) == i_hi) begin
            state <= ST_DRAIN;
          end else begin
            i <= i + AW'(1);
          end
        end
        ST_DRAIN: begin
          if (!mac_stat.busy) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit) begin
            if (last) begin
              first_count   <= '0;
              second_count  <= '0;
              overflow_seen <= 1'b0;
              state         <= ST_IDLE;
            end else begin
              k     <= k_next;
              i     <= i_lo_next[AW-1:0];
              state <= ST_ISSUE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= {2'b00, (empty_run ? PW'(0) : k),
                       (empty_run ? 32'd0 : mac_stat.value)};
      m_axis_tlast <= last;
      m_axis_tuser <= {status, (!empty_run && mac_stat.saturated)};
    end
  end

  pm_ram #(
    .WIDTH(pm_pkg::COEF_W),
    .DEPTH(pm_pkg::MAX_TERMS)
  ) u_first_ram (
    .clk  (clk),
    .we   (load_first && (first_count < CW'(pm_pkg::MAX_TERMS))),
    .waddr(first_count[AW-1:0]),
    .wdata(s_axis_tdata),
    .raddr(i),
    .rdata(first_rd)
  );

  pm_ram #(
    .WIDTH(pm_pkg::COEF_W),
    .DEPTH(pm_pkg::MAX_TERMS)
  ) u_second_ram (
    .clk  (clk),
    .we   (load_second && (second_count < CW'(pm_pkg::MAX_TERMS))),
    .waddr(second_count[AW-1:0]),
    .wdata(s_axis_tdata),
    .raddr(b_index[AW-1:0]),
    .rdata(second_rd)
  );

  pm_mac u_mac (
    .clk (clk),
    .rst (rst),
    .ctl (mac_ctl),
    .a   (first_rd),
    .b   (second_rd),
    .stat(mac_stat)
  );

  `PM_NEVER(a_count_range, (first_count > CW'(pm_pkg::MAX_TERMS)) || (second_count > CW'(pm_pkg::MAX_TERMS)))
  `PM_ASSERT(a_issue_in_range, (state == ST_ISSUE) |-> ((CW'(i) < first_count) && (b_index < PW'(second_count))))
  `PM_ASSERT(a_emit_after_drain, (state == ST_EMIT) |-> !mac_stat.busy)
  `PM_ASSERT(a_last_empties, (emit && last) |=> ((first_count == '0) && (second_count == '0) && !overflow_seen))

endmodule
`default_nettype wire
